FILE: design/gb_pkg.sv
// gb_pkg: shared widths, types and constants for the 5x5 blur
// no dependencies; imported by every module of the block
package gb_pkg;

	// frame limits
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;

	// field and counter widths
	localparam int PIX_W = 8;
	localparam int DIM_W = 9;
	localparam int OUT_W = 8;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT + 3);
	localparam int MAX_W2 = (ROW_W > DIM_W) ? ROW_W : DIM_W;
	localparam int CMP_W = ((MAX_W2 > COL_W) ? MAX_W2 : COL_W) + 2;

	// window geometry
	localparam int KSIZE = 5;
	localparam int KMID  = KSIZE / 2;
	localparam int LINES = KSIZE - 1;
	localparam logic [CMP_W-1:0] HALF = CMP_W'(KMID);

	// sum widths: column sum up to 255*10, total up to 255*100
	localparam int CS_W  = 12;
	localparam int SUM_W = 15;

	// floor(x/100) as (x*5243)>>19, exact for x below 25600
	localparam int RECIP_W = 13;
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W = SUM_W + RECIP_W;

	// register reset values and lower bound
	localparam logic [DIM_W-1:0] DIM_MIN      = 9'd3;
	localparam logic [DIM_W-1:0] WIDTH_RESET  = 9'd160;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 9'd120;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [KSIZE-1:0] pix_col_t;
	typedef logic [CS_W-1:0] csum_t;

	// configuration register indexes
	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// shared read/write control of the line store cells
	typedef struct packed {
		logic             rd_en;
		logic [COL_W-1:0] rd_addr;
		logic             wr_en;
		logic [COL_W-1:0] wr_addr;
	} lb_ctrl_t;

	// kernel is the outer product of 1 2 4 2 1; weight of tap idx as a shift
	function automatic logic [1:0] tap_shift(input int idx);
		logic [1:0] s;
		s = 2'd0;
		if (idx == KMID) begin
			s = 2'd2;
		end else if (idx == KMID - 1 || idx == KMID + 1) begin
			s = 2'd1;
		end
		return s;
	endfunction

endpackage

FILE: design/gb_line_cell.sv
// gb_line_cell: one row delay of the line store, MAX_WIDTH pixels deep
// depends on gb_pkg; chained four deep in the top level
module gb_line_cell import gb_pkg::*; (
	input  logic     clk,
	input  lb_ctrl_t ctrl,
	input  pix_t     wr_data,
	output pix_t     rd_data
);

	pix_t mem_q [MAX_WIDTH];
	pix_t rd_data_q;

	// one write and one registered read per cycle; the user keeps them on different columns, the cell does not enforce it
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem_q[ctrl.wr_addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_data_q <= mem_q[ctrl.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: design/gb_win_cell.sv
// gb_win_cell: one column of the 5x5 window and its row-weighted sum
// depends on gb_pkg; five of these form the shifting window
module gb_win_cell import gb_pkg::*; (
	input  logic     clk,
	input  logic     shift_en,
	input  pix_col_t col_in,
	output pix_col_t col_out,
	output csum_t    colsum
);

	pix_col_t col_q;

	// take the neighbor's column on every shift
	always_ff @(posedge clk) begin
		if (shift_en) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

	// weights 1 2 4 2 1 down the column
	always_comb begin
		colsum = '0;
		for (int k = 0; k < KSIZE; k++) begin
			colsum = colsum + (CS_W'(col_q[k]) << tap_shift(k));
		end
	end

endmodule

FILE: design/gaussian_blur_5x5.sv
// gaussian_blur_5x5: top level of the 5x5 blur over a raster pixel stream
// depends on gb_pkg, gb_line_cell, gb_win_cell
//
// channel  handshake             payload
// cfg      cfg_we                cfg_index, cfg_data (frame_width, frame_height)
// in       in_valid / in_ready   pixel
// out      out_valid / out_ready blurred, column, row, frame_last
//
// takes one word per cycle while in_ready is high; the word that closes a window
// yields its result through line store read, window shift, weighted sum, scale by 1/100
// each frame is width*height pixels then 2*width+2 padding words
// reset sets a 160x120 frame and position (0,0); line stores are not cleared,
// taps outside the frame are zeroed by coordinate instead
// a stall on out fills the four stage registers; in_ready drops only when all are full
module gaussian_blur_5x5 import gb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [PIX_W-1:0] pixel,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] blurred,
	output logic [OUT_W-1:0] column,
	output logic [OUT_W-1:0] row,
	output logic             frame_last
);

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input int maxv);
		logic [DIM_W-1:0] r;
		if (v < DIM_MIN) begin
			r = DIM_MIN;
		end else if (CMP_W'(v) > CMP_W'(maxv)) begin
			r = DIM_W'(maxv);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// registers and position
	logic [DIM_W-1:0] width_q, height_q;
	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;

	// stage control
	logic v_s1, v_s2, v_s3, v_s4;
	logic accept, ld2, ld3, ld4;

	// stage payload
	pix_t             pix_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] ox_s2, ox_s3, ox_s4;
	logic [ROW_W-1:0] oy_s2, oy_s3, oy_s4;
	logic             last_s2, last_s3, last_s4;
	logic [KSIZE-1:0] cmask_s2;
	logic [SUM_W-1:0] sum_s3;
	logic [PROD_W-1:0] prod_s4;

	// stage 1 decode
	logic [CMP_W-1:0] c1, r1, wx, hx, ox_x, oy_x, col_nx;
	logic             have_s1, last_s1, frame_end, row_end;
	logic [KSIZE-1:0] cmask_s1;
	pix_col_t         raw_col, ent_col;

	// line store and window
	lb_ctrl_t lb_ctrl;
	pix_t     lb_wr [LINES];
	pix_t     lb_rd [LINES];
	pix_col_t win_in  [KSIZE];
	pix_col_t win_col [KSIZE];
	csum_t    colsum  [KSIZE];
	logic [SUM_W-1:0] total;

	// handshake and stage advance
	assign ld4      = v_s3 && (!v_s4 || out_ready);
	assign ld3      = v_s2 && (!v_s3 || ld4);
	assign ld2      = v_s1 && (!v_s2 || ld3);
	assign in_ready = !v_s1 || ld2;
	assign accept   = in_valid && in_ready;

	// next input position
	assign wx        = CMP_W'(width_q);
	assign hx        = CMP_W'(height_q);
	assign col_nx    = CMP_W'(in_col_q) + 1'b1;
	assign frame_end = (CMP_W'(in_row_q) == hx + HALF) && (in_col_q != '0);
	assign row_end   = (col_nx >= wx);

	// frame size registers and input position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			in_col_q <= '0;
			in_row_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  width_q  <= clamp_dim(cfg_data, MAX_WIDTH);
				REG_FRAME_HEIGHT: height_q <= clamp_dim(cfg_data, MAX_HEIGHT);
			endcase
			in_col_q <= '0;
			in_row_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				in_col_q <= '0;
				in_row_q <= '0;
			end else if (row_end) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + 1'b1;
			end else begin
				in_col_q <= in_col_q + 1'b1;
			end
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (ld2) begin
				v_s1 <= 1'b0;
			end
			if (ld2) begin
				v_s2 <= have_s1;
			end else if (ld3) begin
				v_s2 <= 1'b0;
			end
			if (ld3) begin
				v_s3 <= 1'b1;
			end else if (ld4) begin
				v_s3 <= 1'b0;
			end
			if (ld4) begin
				v_s4 <= 1'b1;
			end else if (out_ready) begin
				v_s4 <= 1'b0;
			end
		end
	end

	// stage 1: accepted word and its position
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pixel;
			col_s1 <= in_col_q;
			row_s1 <= in_row_q;
		end
	end

	// line store cells: read on accept, write back as the word leaves stage 1
	always_comb begin
		lb_ctrl.rd_en   = accept;
		lb_ctrl.rd_addr = in_col_q;
		lb_ctrl.wr_en   = ld2;
		lb_ctrl.wr_addr = col_s1;
		lb_wr[0] = pix_s1;
		for (int k = 1; k < LINES; k++) begin
			lb_wr[k] = lb_rd[k-1];
		end
	end

	for (genvar k = 0; k < LINES; k++) begin : g_line
		gb_line_cell u_line (
			.clk     (clk),
			.ctrl    (lb_ctrl),
			.wr_data (lb_wr[k]),
			.rd_data (lb_rd[k])
		);
	end

	// output position, column mask and rows of the entering column
	always_comb begin
		c1 = CMP_W'(col_s1);
		r1 = CMP_W'(row_s1);
		if (c1 >= HALF) begin
			have_s1 = (r1 >= HALF);
			ox_x    = c1 - HALF;
			oy_x    = r1 - HALF;
		end else begin
			have_s1 = (r1 >= HALF + 1'b1);
			ox_x    = wx + c1 - HALF;
			oy_x    = r1 - HALF - 1'b1;
		end
		last_s1 = (ox_x == wx - 1'b1) && (oy_x == hx - 1'b1);
		// cell j holds window column ox+2-j
		for (int j = 0; j < KSIZE; j++) begin
			cmask_s1[j] = (ox_x + HALF >= CMP_W'(j)) && (ox_x + HALF - CMP_W'(j) < wx);
		end
		// element k is row r1-k; rows outside the frame enter as zero
		raw_col[0] = pix_s1;
		for (int k = 1; k < KSIZE; k++) begin
			raw_col[k] = lb_rd[k-1];
		end
		for (int k = 0; k < KSIZE; k++) begin
			ent_col[k] = ((r1 >= CMP_W'(k)) && (r1 < hx + CMP_W'(k))) ? raw_col[k] : '0;
		end
	end

	// window cells, newest column at cell 0
	always_comb begin
		win_in[0] = ent_col;
		for (int j = 1; j < KSIZE; j++) begin
			win_in[j] = win_col[j-1];
		end
	end

	for (genvar j = 0; j < KSIZE; j++) begin : g_win
		gb_win_cell u_win (
			.clk      (clk),
			.shift_en (ld2),
			.col_in   (win_in[j]),
			.col_out  (win_col[j]),
			.colsum   (colsum[j])
		);
	end

	// stage 2: position of the window now held
	always_ff @(posedge clk) begin
		if (ld2) begin
			ox_s2    <= COL_W'(ox_x);
			oy_s2    <= ROW_W'(oy_x);
			last_s2  <= last_s1;
			cmask_s2 <= cmask_s1;
		end
	end

	// column-weighted total over the columns inside the frame
	always_comb begin
		total = '0;
		for (int j = 0; j < KSIZE; j++) begin
			if (cmask_s2[j]) begin
				total = total + (SUM_W'(colsum[j]) << tap_shift(j));
			end
		end
	end

	// stage 3: weighted sum
	always_ff @(posedge clk) begin
		if (ld3) begin
			sum_s3  <= total;
			ox_s3   <= ox_s2;
			oy_s3   <= oy_s2;
			last_s3 <= last_s2;
		end
	end

	// stage 4: scale by the reciprocal of 100, held as the output word
	always_ff @(posedge clk) begin
		if (ld4) begin
			prod_s4 <= PROD_W'(sum_s3) * PROD_W'(RECIP_100);
			ox_s4   <= ox_s3;
			oy_s4   <= oy_s3;
			last_s4 <= last_s3;
		end
	end

	assign out_valid  = v_s4;
	assign blurred    = prod_s4[RECIP_SHIFT +: OUT_W];
	assign column     = OUT_W'(ox_s4);
	assign row        = OUT_W'(oy_s4);
	assign frame_last = last_s4;

endmodule

FILE: design/gb_checker.sv
// gb_checker: port-level checks of the 5x5 blur, bound to the top level
// depends on gb_pkg and gaussian_blur_5x5
module gb_checker import gb_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             cfg_we,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [OUT_W-1:0] blurred,
	input logic [OUT_W-1:0] column,
	input logic [OUT_W-1:0] row,
	input logic             frame_last
);

	logic origin_q;

	// next word out opens a frame after reset, a register write or frame_last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= 1'b1;
		end else if (cfg_we) begin
			origin_q <= 1'b1;
		end else if (out_valid && out_ready) begin
			origin_q <= frame_last;
		end
	end

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(blurred) && $stable(column)
			&& $stable(row) && $stable(frame_last))
		else $error("output word changed while stalled");

	// input stalls only when the whole pipeline is backed up by out
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// frame is at least 3x3
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> column >= 8'd2 && row >= 8'd2)
		else $error("frame_last on an impossible position");

	// frame starts at the origin
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && origin_q |-> column == '0 && row == '0)
		else $error("frame does not start at the origin");

endmodule

bind gaussian_blur_5x5 gb_checker u_gb_checker (.*);
